FILE: rtl/core/esc_pkg.sv
// Shared types, constants and helpers of the environmental sensor compensation block.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package esc_pkg;

  // configuration port
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 64;

  localparam logic [CFG_IW-1:0] CFG_TEMP_CAL    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PRESS_CAL_A = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_PRESS_CAL_B = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_PRESS_CAL_C = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_HUM_CAL     = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_FT_OFFSET   = 3'd5;

  // pressure divider: denominator width and quotient bits (one bit per stage)
  localparam int unsigned DENW = 38;
  localparam int unsigned QW   = 34;

  typedef struct packed {
    logic        [15:0] c1;
    logic signed [15:0] c2;
    logic signed [15:0] c3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic         [7:0] h1;
    logic signed [15:0] h2;
    logic         [7:0] h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed  [7:0] h6;
    logic signed [16:0] fto;
  } cal_t;

  // one beat of the restoring divider; w holds dividend bits still to shift in
  // at the top and quotient bits collected at the bottom
  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QW-1:0]   w;
    logic [DENW-1:0] den;
    logic            ovf;
    logic            den_ok;
    logic            neg;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t          r;
    logic [DENW:0] rs;
    logic [DENW:0] diff;
    logic          ge;
    r     = s;
    rs    = {s.rem, s.w[QW-1]};
    diff  = rs - {1'b0, s.den};
    ge    = (rs >= {1'b0, s.den});
    r.rem = ge ? diff[DENW-1:0] : rs[DENW-1:0];
    r.w   = {s.w[QW-2:0], ge};
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/esc_in_if.sv
// Input channel of the compensation block: raw sample beat with valid/ready.
// No dependencies.
`default_nettype none
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;
  logic [15:0] raw_hum;
  logic        read_error;

  modport source (output valid, raw_temp, raw_press, raw_hum, read_error, input ready);
  modport sink   (input valid, raw_temp, raw_press, raw_hum, read_error, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/esc_out_if.sv
// Output channel of the compensation block: compensated result beat with valid/ready.
// No dependencies.
`default_nettype none
interface esc_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] temperature_dc;
  logic        [16:0] pressure_pa;
  logic        [16:0] humidity_q10;
  logic               press_valid;

  modport source (output valid, temperature_dc, pressure_pa, humidity_q10, press_valid,
                  input ready);
  modport sink   (input valid, temperature_dc, pressure_pa, humidity_q10, press_valid,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/env_sensor_compensation_top.sv
// Top level of the environmental sensor compensation block: config registers,
// stage valid bits, alignment delays and output buffer. Depends on esc_pkg and all esc_ modules.
`default_nettype none
// One sample beat enters per clock and one result beat leaves per clock when the sink
// keeps ready high. The beat is captured into the first of 52 pipeline stages at the
// accepting edge (the 34-stage pressure divider, one quotient bit per stage, sets most
// of them) and is loaded from the last stage into the output register. A two-entry
// output buffer lets the pipeline keep moving for one beat after the sink stalls; the
// whole pipeline then holds until space frees. Calibration registers are to be written
// through the plain write port while idle; the user must keep to this, the block does not enforce it.
module env_sensor_compensation_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  esc_in_if.sink                        in_if,
  esc_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [esc_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [esc_pkg::CFG_DW-1:0]    cfg_wdata_i
);
  localparam int unsigned NSTG  = 52;  // stages 0..51
  localparam int unsigned RAWD  = 5;   // raw fields held for stages 0..4
  localparam int unsigned TDLY  = 46;  // temperature, stage 5 to 51
  localparam int unsigned HDLY  = 35;  // humidity, stage 16 to 51

  typedef struct packed {
    logic signed [10:0] t;
    logic        [16:0] pa;
    logic        [16:0] hum;
    logic               ok;
  } res_t;

  logic [47:0] temp_cal_q;
  logic [63:0] press_a_q, press_b_q, hum_cal_q;
  logic [15:0] press_c_q;
  logic [16:0] fto_q;
  esc_pkg::cal_t cal;

  logic            en;
  logic [NSTG-1:0] vld_q;
  logic [19:0]     rt0_q;
  logic [19:0]     rp_q [RAWD];
  logic [15:0]     rh_q [RAWD];
  logic            err_q [NSTG];
  logic signed [10:0] td_q [TDLY];
  logic        [16:0] hd_q [HDLY];

  logic signed [25:0] tf;
  logic signed [10:0] tdc;
  esc_pkg::div_t      div_a, div_b;
  logic        [16:0] pa;
  logic               pok;
  logic        [16:0] hum;

  res_t push_d, o_q, s_q;
  logic push, pop, o_v_q, s_v_q, o_v_d, s_v_d, o_load, s_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      press_a_q  <= '0;
      press_b_q  <= '0;
      press_c_q  <= '0;
      hum_cal_q  <= '0;
      fto_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esc_pkg::CFG_TEMP_CAL:    temp_cal_q <= cfg_wdata_i[47:0];
        esc_pkg::CFG_PRESS_CAL_A: press_a_q  <= cfg_wdata_i;
        esc_pkg::CFG_PRESS_CAL_B: press_b_q  <= cfg_wdata_i;
        esc_pkg::CFG_PRESS_CAL_C: press_c_q  <= cfg_wdata_i[15:0];
        esc_pkg::CFG_HUM_CAL:     hum_cal_q  <= cfg_wdata_i;
        esc_pkg::CFG_FT_OFFSET:   fto_q      <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.c1  = temp_cal_q[15:0];
    cal.c2  = temp_cal_q[31:16];
    cal.c3  = temp_cal_q[47:32];
    cal.p1  = press_a_q[15:0];
    cal.p2  = press_a_q[31:16];
    cal.p3  = press_a_q[47:32];
    cal.p4  = press_a_q[63:48];
    cal.p5  = press_b_q[15:0];
    cal.p6  = press_b_q[31:16];
    cal.p7  = press_b_q[47:32];
    cal.p8  = press_b_q[63:48];
    cal.p9  = press_c_q;
    cal.h1  = hum_cal_q[7:0];
    cal.h2  = hum_cal_q[23:8];
    cal.h3  = hum_cal_q[31:24];
    cal.h4  = hum_cal_q[43:32];
    cal.h5  = hum_cal_q[55:44];
    cal.h6  = hum_cal_q[63:56];
    cal.fto = fto_q;
  end

  // whole pipeline moves while the skid entry is free
  assign en          = !s_v_q;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt0_q    <= in_if.raw_temp;
      rp_q[0]  <= in_if.raw_press;
      rh_q[0]  <= in_if.raw_hum;
      err_q[0] <= in_if.read_error;
      for (int k = 1; k < RAWD; k++) begin
        rp_q[k] <= rp_q[k-1];
        rh_q[k] <= rh_q[k-1];
      end
      for (int k = 1; k < NSTG; k++) begin
        err_q[k] <= err_q[k-1];
      end
      td_q[0] <= tdc;
      for (int k = 1; k < TDLY; k++) begin
        td_q[k] <= td_q[k-1];
      end
      hd_q[0] <= hum;
      for (int k = 1; k < HDLY; k++) begin
        hd_q[k] <= hd_q[k-1];
      end
    end
  end

  esc_temp u_temp (
    .clk_i      (clk_i),
    .en_i       (en),
    .raw_temp_i (rt0_q),
    .cal_i      (cal),
    .tf_o       (tf),
    .temp_dc_o  (tdc)
  );

  esc_pfront u_pfront (
    .clk_i       (clk_i),
    .en_i        (en),
    .tf_i        (tf),
    .raw_press_i (rp_q[RAWD-1]),
    .cal_i       (cal),
    .div_o       (div_a)
  );

  esc_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .div_i (div_a),
    .div_o (div_b)
  );

  esc_pback u_pback (
    .clk_i (clk_i),
    .en_i  (en),
    .div_i (div_b),
    .cal_i (cal),
    .pa_o  (pa),
    .ok_o  (pok)
  );

  esc_hum u_hum (
    .clk_i     (clk_i),
    .en_i      (en),
    .tf_i      (tf),
    .raw_hum_i (rh_q[RAWD-1]),
    .cal_i     (cal),
    .hum_o     (hum)
  );

  // final merge; a bus error blanks everything
  always_comb begin
    push_d.t   = err_q[NSTG-1] ? 11'sd0 : td_q[TDLY-1];
    push_d.pa  = err_q[NSTG-1] ? 17'd0 : pa;
    push_d.hum = (err_q[NSTG-1] || !pok) ? 17'd0 : hd_q[HDLY-1];
    push_d.ok  = pok && !err_q[NSTG-1];
  end

  // two-entry output buffer: o is the visible beat, s catches one beat on a stall
  always_comb begin
    push   = en && vld_q[NSTG-1];
    pop    = o_v_q && out_if.ready;
    o_load = (push && (!o_v_q || pop)) || (!push && pop && s_v_q);
    s_load = push && o_v_q && !pop;
    o_v_d  = o_load ? 1'b1 : (pop ? 1'b0 : o_v_q);
    s_v_d  = s_load ? 1'b1 : ((pop && !push) ? 1'b0 : s_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else begin
      o_v_q <= o_v_d;
      s_v_q <= s_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_q <= push ? push_d : s_q;
    end
    if (s_load) begin
      s_q <= push_d;
    end
  end

  assign out_if.valid          = o_v_q;
  assign out_if.temperature_dc = o_q.t;
  assign out_if.pressure_pa    = o_q.pa;
  assign out_if.humidity_q10   = o_q.hum;
  assign out_if.press_valid    = o_q.ok;
endmodule
`default_nettype wire

FILE: rtl/core/esc_temp.sv
// Temperature stages: fine temperature (4 stages) and 0.1 degC output (1 more).
// Depends on esc_pkg.
`default_nettype none
module esc_temp (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic        [19:0] raw_temp_i,
  input  esc_pkg::cal_t      cal_i,
  output logic signed [25:0] tf_o,
  output logic signed [10:0] temp_dc_o
);
  logic signed [18:0] d1_d, d1_q;
  logic signed [17:0] d2_d, d2_q;
  logic signed [34:0] m1_d, m1_q;
  logic signed [35:0] sq_d, sq_q;
  logic signed [23:0] at_d, at_q;
  logic signed [39:0] m2_d, m2_q;
  logic signed [25:0] tf_d, tf_q;
  logic signed [26:0] tabs;
  logic        [17:0] tmag;
  logic signed [18:0] tq;
  logic signed [10:0] tdc_d, tdc_q;

  always_comb begin
    d1_d = $signed({2'b00, raw_temp_i[19:3]}) - $signed({2'b00, cal_i.c1, 1'b0});
    d2_d = $signed({2'b00, raw_temp_i[19:4]}) - $signed({2'b00, cal_i.c1});
    m1_d = 35'(d1_q) * 35'(cal_i.c2);
    sq_d = 36'(d2_q) * 36'(d2_q);
    at_d = 24'(m1_q >>> 11);
    m2_d = 40'(sq_q >>> 12) * 40'(cal_i.c3);
    tf_d = 26'(at_q) + 26'(m2_q >>> 14) - 26'(cal_i.fto);
    // divide by 512 toward zero
    tabs = tf_q[25] ? -27'(tf_q) : 27'(tf_q);
    tmag = tabs[26:9];
    tq   = tf_q[25] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    if (tq < -19'sd400) begin
      tdc_d = -11'sd400;
    end else if (tq > 19'sd850) begin
      tdc_d = 11'sd850;
    end else begin
      tdc_d = 11'(tq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q  <= d1_d;
      d2_q  <= d2_d;
      m1_q  <= m1_d;
      sq_q  <= sq_d;
      at_q  <= at_d;
      m2_q  <= m2_d;
      tf_q  <= tf_d;
      tdc_q <= tdc_d;
    end
  end

  assign tf_o      = tf_q;
  assign temp_dc_o = tdc_q;
endmodule
`default_nettype wire

FILE: rtl/core/esc_pfront.sv
// Pressure front end: var terms, denominator and scaled numerator (8 stages),
// ending in the divider's first beat. Depends on esc_pkg.
`default_nettype none
module esc_pfront (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [25:0] tf_i,
  input  logic        [19:0] raw_press_i,
  input  esc_pkg::cal_t      cal_i,
  output esc_pkg::div_t      div_o
);
  logic signed [25:0] v1_d, v1_q;
  logic        [19:0] adc5_q, adc6_q, adc7_q, adc8_q;
  logic signed [51:0] v1sq_d, v1sq_q;
  logic signed [41:0] mp5_d, mp5_q, mp2_d, mp2_q, mp5b_q, mp2b_q;
  logic signed [63:0] t6_d, t6_q, t3_d, t3_q;
  logic signed [63:0] v2_d, v2_q, a_d, a_q;
  logic        [20:0] pn;
  logic signed [63:0] num_d, num_q;
  logic signed [71:0] ap_d, ap_q, denf;
  logic        [63:0] absn_d, absn_q;
  logic [esc_pkg::DENW-1:0] den10_q, den11_q;
  logic               ok10_d, ok10_q, ok11_q, neg10_q, neg11_q;
  logic        [75:0] nm_d, nm_q;
  logic        [41:0] r0;
  esc_pkg::div_t      div_d, div_q;

  always_comb begin
    v1_d   = tf_i - 26'sd128000;
    v1sq_d = 52'(v1_q) * 52'(v1_q);
    mp5_d  = 42'(v1_q) * 42'(cal_i.p5);
    mp2_d  = 42'(v1_q) * 42'(cal_i.p2);
    t6_d   = 64'(v1sq_q) * 64'(cal_i.p6);
    t3_d   = 64'(v1sq_q) * 64'(cal_i.p3);
    v2_d   = t6_q + (64'(mp5b_q) <<< 17) + (64'(cal_i.p4) <<< 35);
    a_d    = (t3_q >>> 8) + (64'(mp2b_q) <<< 12) + 64'sh0000_8000_0000_0000;
    pn     = 21'h100000 - {1'b0, adc8_q};
    num_d  = $signed({12'b0, pn, 31'b0}) - v2_q;
    ap_d   = 72'(a_q) * 72'($signed({1'b0, cal_i.p1}));
    denf   = ap_q >>> 33;
    ok10_d = (denf > 72'sd0);
    absn_d = num_q[63] ? $unsigned(-num_q) : $unsigned(num_q);
    nm_d   = 76'(absn_q) * 76'(12'd3125);
    // quotient must fit QW bits, else it saturates anyway
    r0           = nm_q[75:34];
    div_d.ovf    = (r0 >= {4'b0, den11_q});
    div_d.rem    = r0[esc_pkg::DENW-1:0];
    div_d.w      = nm_q[33:0];
    div_d.den    = den11_q;
    div_d.den_ok = ok11_q;
    div_d.neg    = neg11_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q    <= v1_d;
      adc5_q  <= raw_press_i;
      adc6_q  <= adc5_q;
      adc7_q  <= adc6_q;
      adc8_q  <= adc7_q;
      v1sq_q  <= v1sq_d;
      mp5_q   <= mp5_d;
      mp2_q   <= mp2_d;
      mp5b_q  <= mp5_q;
      mp2b_q  <= mp2_q;
      t6_q    <= t6_d;
      t3_q    <= t3_d;
      v2_q    <= v2_d;
      a_q     <= a_d;
      num_q   <= num_d;
      ap_q    <= ap_d;
      absn_q  <= absn_d;
      den10_q <= denf[esc_pkg::DENW-1:0];
      ok10_q  <= ok10_d;
      neg10_q <= num_q[63];
      nm_q    <= nm_d;
      den11_q <= den10_q;
      ok11_q  <= ok10_q;
      neg11_q <= neg10_q;
      div_q   <= div_d;
    end
  end

  assign div_o = div_q;
endmodule
`default_nettype wire

FILE: rtl/core/esc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on esc_pkg.
`default_nettype none
module esc_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  esc_pkg::div_t div_i,
  output esc_pkg::div_t div_o
);
  esc_pkg::div_t stg_d [esc_pkg::QW];
  esc_pkg::div_t stg_q [esc_pkg::QW];

  always_comb begin
    stg_d[0] = esc_pkg::div_step(div_i);
    for (int k = 1; k < esc_pkg::QW; k++) begin
      stg_d[k] = esc_pkg::div_step(stg_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < esc_pkg::QW; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign div_o = stg_q[esc_pkg::QW-1];
endmodule
`default_nettype wire

FILE: rtl/core/esc_pback.sv
// Pressure back end: saturate quotient, second-order correction, pascal output
// (5 stages). Depends on esc_pkg.
`default_nettype none
module esc_pback (
  input  logic          clk_i,
  input  logic          en_i,
  input  esc_pkg::div_t div_i,
  input  esc_pkg::cal_t cal_i,
  output logic   [16:0] pa_o,
  output logic          ok_o
);
  logic        [33:0] mag;
  logic signed [35:0] p_d, p_q, p48_q, p49_q, ps;
  logic signed [45:0] pss_d, pss_q;
  logic signed [51:0] e2m_d, e2m_q, e2m49_q;
  logic signed [61:0] e1m_d, e1m_q;
  logic signed [39:0] sum, pq8_d, pq8_q, pp;
  logic        [16:0] pa_d, pa_q;
  logic               ok47_q, ok48_q, ok49_q, ok50_q, ok51_q;

  always_comb begin
    mag = (div_i.ovf || (div_i.w > 34'h2_0000_0000)) ? 34'h2_0000_0000 : div_i.w;
    p_d = div_i.neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
    ps    = p_q >>> 13;
    pss_d = 46'(ps) * 46'(ps);
    e2m_d = 52'(cal_i.p8) * 52'(p_q);
    e1m_d = 62'(pss_q) * 62'(cal_i.p9);
    sum   = 40'(p49_q) + 40'(e1m_q >>> 25) + 40'(e2m49_q >>> 19);
    pq8_d = (sum >>> 8) + (40'(cal_i.p7) <<< 4);
    pp    = pq8_q >>> 8;
    if (!ok50_q || pp < 40'sd0) begin
      pa_d = '0;
    end else if (pp > 40'sd131071) begin
      pa_d = 17'h1FFFF;
    end else begin
      pa_d = 17'(pp);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      ok47_q  <= div_i.den_ok;
      pss_q   <= pss_d;
      e2m_q   <= e2m_d;
      p48_q   <= p_q;
      ok48_q  <= ok47_q;
      e1m_q   <= e1m_d;
      e2m49_q <= e2m_q;
      p49_q   <= p48_q;
      ok49_q  <= ok48_q;
      pq8_q   <= pq8_d;
      ok50_q  <= ok49_q;
      pa_q    <= pa_d;
      ok51_q  <= ok50_q;
    end
  end

  assign pa_o = pa_q;
  assign ok_o = ok51_q;
endmodule
`default_nettype wire

FILE: rtl/core/esc_hum.sv
// Humidity stages: 32-bit formula with saturation, result >>12 (12 stages).
// Depends on esc_pkg.
`default_nettype none
module esc_hum (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [25:0] tf_i,
  input  logic        [15:0] raw_hum_i,
  input  esc_pkg::cal_t      cal_i,
  output logic        [16:0] hum_o
);
  logic signed [25:0] vh_d, vh_q;
  logic        [15:0] adc5_q, adc6_q;
  logic signed [37:0] mh5_d, mh5_q;
  logic signed [33:0] mh6_d, mh6_q;
  logic signed [34:0] mh3_d, mh3_q;
  logic signed [39:0] xs;
  logic signed [23:0] x7_d, x7_q, x8_q, x9_q, x10_q, x11_q;
  logic signed [23:0] a6_d, a6_q, b3_d, b3_q;
  logic signed [47:0] prod_d, prod_q;
  logic signed [39:0] inner_d, inner_q;
  logic signed [55:0] ih_d, ih_q;
  logic signed [41:0] y_d, y_q;
  logic signed [63:0] xy_d, xy_q;
  logic signed [31:0] v13_d, v13_q, v14_q, v15_q, t;
  logic signed [33:0] tt_d, tt_q;
  logic signed [43:0] u_d, u_q;
  logic signed [39:0] w;
  logic        [16:0] hum_d, hum_q;

  always_comb begin
    vh_d  = tf_i - 26'sd76800;
    mh5_d = 38'(cal_i.h5) * 38'(vh_q);
    mh6_d = 34'(vh_q) * 34'(cal_i.h6);
    mh3_d = 35'(vh_q) * 35'($signed({1'b0, cal_i.h3}));
    xs    = 40'($signed({1'b0, adc6_q, 14'b0})) - (40'(cal_i.h4) <<< 20)
            - 40'(mh5_q) + 40'sd16384;
    x7_d  = 24'(xs >>> 15);
    a6_d  = 24'(mh6_q >>> 10);
    b3_d  = 24'(mh3_q >>> 11) + 24'sd32768;
    prod_d  = 48'(a6_q) * 48'(b3_q);
    inner_d = 40'(prod_q >>> 10) + 40'sd2097152;
    ih_d    = 56'(inner_q) * 56'(cal_i.h2);
    y_d     = 42'((ih_q + 56'sd8192) >>> 14);
    xy_d    = 64'(x11_q) * 64'(y_q);
    if (xy_q < -64'sd2147483648) begin
      v13_d = {1'b1, 31'b0};
    end else if (xy_q > 64'sd2147483647) begin
      v13_d = {1'b0, {31{1'b1}}};
    end else begin
      v13_d = 32'(xy_q);
    end
    t    = v13_q >>> 15;
    tt_d = 34'(t) * 34'(t);
    u_d  = 44'(tt_q >>> 7) * 44'($signed({1'b0, cal_i.h1}));
    w    = 40'(v15_q) - 40'(u_q >>> 4);
    if (w < 40'sd0) begin
      hum_d = '0;
    end else if (w > 40'sd419430400) begin
      hum_d = 17'd102400;
    end else begin
      hum_d = 17'(w >>> 12);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vh_q    <= vh_d;
      adc5_q  <= raw_hum_i;
      adc6_q  <= adc5_q;
      mh5_q   <= mh5_d;
      mh6_q   <= mh6_d;
      mh3_q   <= mh3_d;
      x7_q    <= x7_d;
      a6_q    <= a6_d;
      b3_q    <= b3_d;
      prod_q  <= prod_d;
      x8_q    <= x7_q;
      inner_q <= inner_d;
      x9_q    <= x8_q;
      ih_q    <= ih_d;
      x10_q   <= x9_q;
      y_q     <= y_d;
      x11_q   <= x10_q;
      xy_q    <= xy_d;
      v13_q   <= v13_d;
      tt_q    <= tt_d;
      v14_q   <= v13_q;
      u_q     <= u_d;
      v15_q   <= v14_q;
      hum_q   <= hum_d;
    end
  end

  assign hum_o = hum_q;
endmodule
`default_nettype wire

FILE: tb/tb_env_sensor_compensation_top.sv
// Testbench for env_sensor_compensation_top: bursty sample driver, stalling result sink,
// in-line compensation predictor and a queue of expected results.
// Depends on esc_pkg, esc_in_if, esc_out_if and the RTL under rtl/core.
`default_nettype none
module tb_env_sensor_compensation_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
    logic        read_error;
  } sample_t;

  typedef struct packed {
    logic [10:0] temperature_dc;
    logic [16:0] pressure_pa;
    logic [16:0] humidity_q10;
    logic        press_valid;
  } reading_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [47:0] TEMP_TYP  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] PRESSA_TYP = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] PRESSB_TYP = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [15:0] PRESSC_TYP = 16'd6000;
  localparam logic [63:0] HUM_TYP   = {8'd30, 12'd0, 12'd324, 8'd0, 16'd362, 8'd75};

  logic clk_i;
  logic rst_ni;
  logic                         cfg_we;
  logic [esc_pkg::CFG_IW-1:0]   cfg_idx;
  logic [esc_pkg::CFG_DW-1:0]   cfg_wdata;

  esc_in_if  in_if ();
  esc_out_if out_if ();

  env_sensor_compensation_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // calibration mirror
  logic [47:0] temp_cal;
  logic [63:0] press_cal_a, press_cal_b, hum_cal;
  logic [15:0] press_cal_c;
  logic [16:0] ft_offset;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int unsigned n_errors;

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic reading_t compensate(sample_t s);
    longint adc_t, adc_p, adc_h;
    longint c1, c2, c3, d1, d2, tf, t;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint v1, v2, a, q, r, den, num, qq, rr, p, e1, e2, pq8, pa;
    longint h1, h2, h3, h4, h5, h6, v, x, inner, y, tq, hum;
    longint fto;
    bit ok;
    reading_t o;
    adc_t = s.raw_temp;
    adc_p = s.raw_press;
    adc_h = s.raw_hum;
    c1 = temp_cal[15:0];
    c2 = $signed(temp_cal[31:16]);
    c3 = $signed(temp_cal[47:32]);
    fto = $signed(ft_offset);
    d1 = (adc_t >>> 3) - c1 * 2;
    d2 = (adc_t >>> 4) - c1;
    tf = ((d1 * c2) >>> 11) + (((((d2 * d2) >>> 12) * c3)) >>> 14) - fto;
    t = tf < 0 ? -((-tf) >>> 9) : (tf >>> 9);
    t = clamp(t, -400, 850);

    p1 = press_cal_a[15:0];
    p2 = $signed(press_cal_a[31:16]);
    p3 = $signed(press_cal_a[47:32]);
    p4 = $signed(press_cal_a[63:48]);
    p5 = $signed(press_cal_b[15:0]);
    p6 = $signed(press_cal_b[31:16]);
    p7 = $signed(press_cal_b[47:32]);
    p8 = $signed(press_cal_b[63:48]);
    p9 = $signed(press_cal_c);
    v1 = tf - 128000;
    v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * 64'sd34359738368;
    a = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096 + 64'sd140737488355328;
    q = a >>> 17;
    r = a - q * 131072;
    den = (q * p1 + ((r * p1) >>> 17)) >>> 16;
    ok = den >= 1;
    pa = 0;
    hum = 0;
    if (ok) begin
      num = (1048576 - adc_p) * 64'sd2147483648 - v2;
      qq = num / den;
      rr = num % den;
      if (qq > 4194304) p = 64'sd8589934592;
      else if (qq < -4194304) p = -64'sd8589934592;
      else p = clamp(qq * 3125 + (rr * 3125) / den, -64'sd8589934592, 64'sd8589934592);
      e1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      e2 = (p8 * p) >>> 19;
      pq8 = ((p + e1 + e2) >>> 8) + p7 * 16;
      pa = clamp(pq8 >>> 8, 0, 131071);

      h1 = hum_cal[7:0];
      h2 = $signed(hum_cal[23:8]);
      h3 = hum_cal[31:24];
      h4 = $signed(hum_cal[43:32]);
      h5 = $signed(hum_cal[55:44]);
      h6 = $signed(hum_cal[63:56]);
      v = tf - 76800;
      x = (adc_h * 16384 - h4 * 1048576 - h5 * v + 16384) >>> 15;
      inner = ((((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768)) >>> 10) + 2097152;
      y = (inner * h2 + 8192) >>> 14;
      v = clamp(x * y, -64'sd2147483648, 64'sd2147483647);
      tq = v >>> 15;
      v = v - ((((tq * tq) >>> 7) * h1) >>> 4);
      v = clamp(v, 0, 419430400);
      hum = v >>> 12;
    end
    if (s.read_error) begin
      t = 0;
      pa = 0;
      hum = 0;
      ok = 0;
    end
    o.temperature_dc = t[10:0];
    o.pressure_pa    = pa[16:0];
    o.humidity_q10   = hum[16:0];
    o.press_valid    = ok;
    return o;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sample driver: bursts of random length separated by random gaps
  int unsigned burst_left, gap_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_readings.push_back(compensate({in_if.raw_temp, in_if.raw_press,
                                                in_if.raw_hum, in_if.read_error}));
      if (in_if.valid && !in_if.ready) begin
        // hold the beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_if.valid      <= 1'b1;
        in_if.raw_temp   <= s.raw_temp;
        in_if.raw_press  <= s.raw_press;
        in_if.raw_hum    <= s.raw_hum;
        in_if.read_error <= s.read_error;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink stall pattern, with two long hold-offs to back up the pipeline
  int unsigned sink_cycle, sink_hold, sink_mode;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_cycle <= 0;
      sink_hold <= 0;
      sink_mode <= 0;
    end else begin
      sink_cycle <= sink_cycle + 1;
      if (sink_cycle % 64 == 0) sink_mode <= $urandom_range(0, 3);
      if (sink_cycle == 1500 || sink_cycle == 7000) begin
        sink_hold <= 300;
        out_if.ready <= 1'b0;
      end else if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 9) != 0);
          default: out_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_readings.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        reading_t e;
        e = expected_readings.pop_front();
        if (out_if.temperature_dc !== e.temperature_dc) begin
          $error("temperature_dc expected %0d got %0d", $signed(e.temperature_dc),
                 out_if.temperature_dc);
          n_errors++;
        end
        if (out_if.pressure_pa !== e.pressure_pa) begin
          $error("pressure_pa expected %0d got %0d", e.pressure_pa, out_if.pressure_pa);
          n_errors++;
        end
        if (out_if.humidity_q10 !== e.humidity_q10) begin
          $error("humidity_q10 expected %0d got %0d", e.humidity_q10, out_if.humidity_q10);
          n_errors++;
        end
        if (out_if.press_valid !== e.press_valid) begin
          $error("press_valid expected %0d got %0d", e.press_valid, out_if.press_valid);
          n_errors++;
        end
      end
    end
  end

  int unsigned cycle_count;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_env_sensor_compensation_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [esc_pkg::CFG_IW-1:0] idx, logic [esc_pkg::CFG_DW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      esc_pkg::CFG_TEMP_CAL:    temp_cal    = data[47:0];
      esc_pkg::CFG_PRESS_CAL_A: press_cal_a = data;
      esc_pkg::CFG_PRESS_CAL_B: press_cal_b = data;
      esc_pkg::CFG_PRESS_CAL_C: press_cal_c = data[15:0];
      esc_pkg::CFG_HUM_CAL:     hum_cal     = data;
      esc_pkg::CFG_FT_OFFSET:   ft_offset   = data[16:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                          logic [15:0] pc, logic [63:0] hc, logic [16:0] fo);
    write_reg(esc_pkg::CFG_TEMP_CAL, {16'd0, tc});
    write_reg(esc_pkg::CFG_PRESS_CAL_A, pa);
    write_reg(esc_pkg::CFG_PRESS_CAL_B, pb);
    write_reg(esc_pkg::CFG_PRESS_CAL_C, {48'd0, pc});
    write_reg(esc_pkg::CFG_HUM_CAL, hc);
    write_reg(esc_pkg::CFG_FT_OFFSET, {47'd0, fo});
  endtask

  // sender waits until every expected result is back, then the pipeline drains
  task automatic drain();
    while (pending_samples.size() > 0 || expected_readings.size() > 0 || in_if.valid)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    s.raw_temp   = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                              : 20'($urandom_range(450000, 580000));
    s.raw_press  = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                              : 20'($urandom_range(250000, 500000));
    s.raw_hum    = 16'($urandom);
    s.read_error = ($urandom_range(0, 9) == 0);
    return s;
  endfunction

  task automatic push_random(int unsigned n);
    repeat (n) pending_samples.push_back(random_sample());
  endtask

  initial begin
    n_errors = 0;
    cycle_count = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.raw_temp = '0;
    in_if.raw_press = '0;
    in_if.raw_hum = '0;
    in_if.read_error = 1'b0;
    out_if.ready = 1'b0;
    temp_cal = '0;
    press_cal_a = '0;
    press_cal_b = '0;
    press_cal_c = '0;
    hum_cal = '0;
    ft_offset = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // all-zero calibration: denominator is zero, pressure and humidity invalid
    pending_samples.push_back({20'd0, 20'd0, 16'd0, 1'b0});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0});
    pending_samples.push_back({20'd519888, 20'd415148, 16'd30000, 1'b1});
    drain();

    load_cal(TEMP_TYP, PRESSA_TYP, PRESSB_TYP, PRESSC_TYP, HUM_TYP, 17'd0);
    // directed: field extremes, typical readings, bus error, saturating temperature
    pending_samples.push_back({20'd519888, 20'd415148, 16'd30000, 1'b0});
    pending_samples.push_back({20'd519888, 20'd415148, 16'd30000, 1'b1});
    pending_samples.push_back({20'd0, 20'd415148, 16'd30000, 1'b0});
    pending_samples.push_back({20'hFFFFF, 20'd415148, 16'd30000, 1'b0});
    pending_samples.push_back({20'd519888, 20'd0, 16'd0, 1'b0});
    pending_samples.push_back({20'd519888, 20'hFFFFF, 16'hFFFF, 1'b0});
    pending_samples.push_back({20'd519888, 20'h80000, 16'h8000, 1'b0});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1});
    pending_samples.push_back({20'd450000, 20'd300000, 16'd0, 1'b0});
    pending_samples.push_back({20'd600000, 20'd500000, 16'd65535, 1'b0});
    pending_samples.push_back({20'h55555, 20'hAAAAA, 16'h5555, 1'b0});
    pending_samples.push_back({20'hAAAAA, 20'h55555, 16'hAAAA, 1'b0});
    push_random(300);
    drain();

    // perturbed typical calibration, random offset
    load_cal(TEMP_TYP ^ (48'($urandom) & 48'h00FF_00FF_0FFF),
             PRESSA_TYP ^ (64'($urandom) & 64'h00FF_00FF_00FF_0FFF),
             PRESSB_TYP ^ ({32'($urandom), 32'($urandom)} & 64'h00FF_00FF_00FF_00FF),
             PRESSC_TYP ^ 16'($urandom_range(0, 255)),
             HUM_TYP ^ ({32'($urandom), 32'($urandom)} & 64'h0F0F_F0FF_0F00_FF0F),
             17'($urandom_range(0, 20000)) - 17'd10000);
    push_random(300);
    drain();

    // fully random calibration: exercises humidity product and quotient saturation
    load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
             16'($urandom), {$urandom, $urandom}, 17'($urandom));
    push_random(250);
    drain();

    // extremes: all-ones registers but most negative pressure C, most negative offset
    load_cal('1, '1, '1, 16'h8000, '1, 17'h10000);
    push_random(150);
    drain();

    // typical but most positive pressure C, with most positive offset
    load_cal(TEMP_TYP, PRESSA_TYP, PRESSB_TYP, 16'h7FFF, HUM_TYP, 17'h0FFFF);
    push_random(150);
    drain();

    load_cal(TEMP_TYP, PRESSA_TYP, PRESSB_TYP, PRESSC_TYP, HUM_TYP, 17'd0);
    push_random(350);
    drain();

    repeat (60) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_env_sensor_compensation_top: PASS");
    end else begin
      $display("tb_env_sensor_compensation_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/esc_pkg.sv
rtl/core/esc_in_if.sv
rtl/core/esc_out_if.sv
rtl/core/esc_temp.sv
rtl/core/esc_pfront.sv
rtl/core/esc_div.sv
rtl/core/esc_pback.sv
rtl/core/esc_hum.sv
rtl/core/env_sensor_compensation_top.sv
tb/tb_env_sensor_compensation_top.sv
